// ===== sv/lfu_pr_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU page replacement package
// Field widths, default sizes and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package lfu_pr_pkg;

   localparam int PAGE_W  = 8;
   localparam int IDX_W   = 3;
   localparam int TOTAL_W = 16;
   localparam int CFG_W   = 4;

   localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

   localparam int NUM_FRAMES_DEF  = 8;
   localparam int PAGE_SPACE_DEF  = 256;
   localparam int COUNT_WIDTH_DEF = 16;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_CNT_RD,
      ST_CNT_WR
   } lfu_pr_state_type;

endpackage

// ===== sv/lfu_pr_if.sv =====
// ----------------------------------------------------------------------------
// LFU page replacement channels
// Valid/ready channels for page references, results and the frame count.
// ----------------------------------------------------------------------------
interface lfu_pr_req_if;
   import lfu_pr_pkg::*;

   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lfu_pr_rsp_if;
   import lfu_pr_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [IDX_W-1:0]   frame_index;
   logic               evicted_valid;
   logic [PAGE_W-1:0]  evicted_page;
   logic [TOTAL_W-1:0] hit_total;
   logic [TOTAL_W-1:0] miss_total;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output hit_total, output miss_total, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input hit_total, input miss_total, output ready);
endinterface

interface lfu_pr_csr_if;
   import lfu_pr_pkg::*;

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink   (input valid, input frames_in_use, output ready);
endinterface

// ===== sv/lfu_pr_ram.sv =====
// ----------------------------------------------------------------------------
// LFU generic RAM
// One write port, one read port, registered read data held when not read.
// ----------------------------------------------------------------------------
module lfu_pr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lfu_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// LFU page replacement core
// Resolves page references against a small set of frames, LFU victim choice.
// ----------------------------------------------------------------------------
// req_chan takes one page reference per item; rsp_chan returns one result
// item per reference: hit flag, frame holding the page, evicted page if any,
// and saturating hit and miss totals. csr_chan writes frames_in_use (0 acts
// as 1, values above NUM_FRAMES as NUM_FRAMES); it is always ready. The user
// must write it only while no item is in flight; the block does not enforce it.
// After reset the per-page count memory is cleared, one entry per cycle;
// req_chan.ready stays low meanwhile.
// An item is resolved by a single scan of the n frames in use: each cycle
// one frame page is read from the frame RAM, its count is read from the
// count RAM in the next, and the scan tracks hit, first empty frame
// and least counted frame. After the scan the referenced page's count is
// read in ST_CNT_RD and written back in ST_CNT_WR, which waits for the
// output register to be free. The next item is taken only when the core
// is back in ST_IDLE, after the previous one has been written back.
// The result sits in an output register: a stalled receiver does not stop
// the next item being accepted, only its result being written back.
// ----------------------------------------------------------------------------
module lfu_page_replacement_core #(
   parameter int NUM_FRAMES  = lfu_pr_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_SPACE  = lfu_pr_pkg::PAGE_SPACE_DEF,
   parameter int COUNT_WIDTH = lfu_pr_pkg::COUNT_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   lfu_pr_req_if.sink   req_chan,
   lfu_pr_rsp_if.source rsp_chan,
   lfu_pr_csr_if.sink   csr_chan
);
   import lfu_pr_pkg::*;

   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int NW = $clog2(NUM_FRAMES + 1);
   localparam int PW = $clog2(PAGE_SPACE);
   localparam int CW = COUNT_WIDTH;

   lfu_pr_state_type state_ff, state_in;

   logic [PW-1:0]         clr_ff;
   logic [CFG_W-1:0]      fiu_ff;
   logic [PW-1:0]         page_ff;
   logic [NW-1:0]         iss_ff;
   logic                  s1_vld_ff;
   logic [FW-1:0]         s1_idx_ff;
   logic                  s2_vld_ff;
   logic [FW-1:0]         s2_idx_ff;
   logic [PW-1:0]         s2_page_ff;
   logic                  hit_ff;
   logic [FW-1:0]         hit_idx_ff;
   logic                  emp_ff;
   logic [FW-1:0]         emp_idx_ff;
   logic [CW-1:0]         min_cnt_ff;
   logic [FW-1:0]         min_idx_ff;
   logic [PW-1:0]         min_page_ff;
   logic [NUM_FRAMES-1:0] fv_ff;
   logic [TOTAL_W-1:0]    hits_ff;
   logic [TOTAL_W-1:0]    misses_ff;

   logic                  rsp_vld_ff;
   logic                  rsp_hit_ff;
   logic [IDX_W-1:0]      rsp_idx_ff;
   logic                  rsp_ev_ff;
   logic [PAGE_W-1:0]     rsp_evp_ff;
   logic [TOTAL_W-1:0]    rsp_ht_ff;
   logic [TOTAL_W-1:0]    rsp_mt_ff;

   logic [NW-1:0]         n_act;
   logic [PW-1:0]         req_page_red;
   logic [PAGE_W-1:0]     rem;
   logic                  accept;
   logic                  issue;
   logic                  commit;
   logic                  clearing;
   logic [FW-1:0]         slot;
   logic                  evict;

   logic                  fp_wr_en;
   logic [PW-1:0]         fp_rd_data;
   logic                  cnt_wr_en;
   logic [PW-1:0]         cnt_wr_addr;
   logic [CW-1:0]         cnt_wr_data;
   logic                  cnt_rd_en;
   logic [PW-1:0]         cnt_rd_addr;
   logic [CW-1:0]         cnt_rd_data;
   logic [CW-1:0]         cnt_inc;

   // page modulo page space, restoring compare-subtract
   always_comb begin
      rem = req_chan.page;
      for (int k = PAGE_W - 1; k >= 0; k--) begin
         if (32'(rem) >= (PAGE_SPACE << k)) begin
            rem = rem - PAGE_W'(PAGE_SPACE << k);
         end
      end
      req_page_red = PW'(rem);
   end

   always_comb begin
      if (fiu_ff == '0) begin
         n_act = NW'(1);
      end else if (32'(fiu_ff) > NUM_FRAMES) begin
         n_act = NW'(NUM_FRAMES);
      end else begin
         n_act = NW'(fiu_ff);
      end
   end

   assign slot  = hit_ff ? hit_idx_ff : (emp_ff ? emp_idx_ff : min_idx_ff);
   assign evict = !hit_ff && !emp_ff;
   assign cnt_inc = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      issue     = 1'b0;
      commit    = 1'b0;
      clearing  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            if (clr_ff == PW'(PAGE_SPACE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               accept   = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue = (iss_ff < n_act);
            if (s2_vld_ff && s2_idx_ff == FW'(n_act - NW'(1))) begin
               state_in  = ST_CNT_RD;
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         fiu_ff     <= FRAMES_RESET;
         fv_ff      <= '0;
         hits_ff    <= '0;
         misses_ff  <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (clearing) begin
            clr_ff <= clr_ff + PW'(1);
         end
         if (csr_chan.valid) begin
            fiu_ff <= csr_chan.frames_in_use;
         end
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         if (commit) begin
            fv_ff[slot] <= 1'b1;
            if (hit_ff) begin
               if (hits_ff != '1) begin
                  hits_ff <= hits_ff + TOTAL_W'(1);
               end
            end else if (misses_ff != '1) begin
               misses_ff <= misses_ff + TOTAL_W'(1);
            end
         end
         if (commit) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page_red;
         iss_ff  <= '0;
         hit_ff  <= 1'b0;
         emp_ff  <= 1'b0;
      end
      if (issue) begin
         iss_ff <= iss_ff + NW'(1);
      end
      s1_idx_ff  <= iss_ff[FW-1:0];
      s2_idx_ff  <= s1_idx_ff;
      s2_page_ff <= fp_rd_data;
      if (s1_vld_ff) begin
         if (!hit_ff && fv_ff[s1_idx_ff] && fp_rd_data == page_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= s1_idx_ff;
         end
         if (!emp_ff && !fv_ff[s1_idx_ff]) begin
            emp_ff     <= 1'b1;
            emp_idx_ff <= s1_idx_ff;
         end
      end
      if (s2_vld_ff && (s2_idx_ff == '0 || cnt_rd_data < min_cnt_ff)) begin
         min_cnt_ff  <= cnt_rd_data;
         min_idx_ff  <= s2_idx_ff;
         min_page_ff <= s2_page_ff;
      end
      if (commit) begin
         rsp_hit_ff <= hit_ff;
         rsp_idx_ff <= IDX_W'(slot);
         rsp_ev_ff  <= evict;
         rsp_evp_ff <= evict ? PAGE_W'(min_page_ff) : '0;
         if (hit_ff) begin
            rsp_ht_ff <= (hits_ff != '1) ? hits_ff + TOTAL_W'(1) : hits_ff;
            rsp_mt_ff <= misses_ff;
         end else begin
            rsp_ht_ff <= hits_ff;
            rsp_mt_ff <= (misses_ff != '1) ? misses_ff + TOTAL_W'(1) : misses_ff;
         end
      end
   end

   assign fp_wr_en    = commit && !hit_ff;
   assign cnt_wr_en   = clearing || commit;
   assign cnt_wr_addr = clearing ? clr_ff : page_ff;
   assign cnt_wr_data = clearing ? '0 : cnt_inc;
   assign cnt_rd_en   = s1_vld_ff || (state_ff == ST_CNT_RD);
   assign cnt_rd_addr = (state_ff == ST_CNT_RD) ? page_ff : fp_rd_data;

   lfu_pr_ram #(
      .WIDTH (PW),
      .DEPTH (NUM_FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (fp_wr_en),
      .wr_addr (slot),
      .wr_data (page_ff),
      .rd_en   (issue),
      .rd_addr (iss_ff[FW-1:0]),
      .rd_data (fp_rd_data)
   );

   lfu_pr_ram #(
      .WIDTH (CW),
      .DEPTH (PAGE_SPACE)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.frame_index   = rsp_idx_ff;
   assign rsp_chan.evicted_valid = rsp_ev_ff;
   assign rsp_chan.evicted_page  = rsp_evp_ff;
   assign rsp_chan.hit_total     = rsp_ht_ff;
   assign rsp_chan.miss_total    = rsp_mt_ff;

endmodule

// ===== sv/lfu_pr_checker.sv =====
// ----------------------------------------------------------------------------
// LFU page replacement checker
// Port-level properties of the core, bound to the core module.
// ----------------------------------------------------------------------------
module lfu_pr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic                        rsp_evicted_valid,
   input logic [lfu_pr_pkg::PAGE_W-1:0] rsp_evicted_page
);
   import lfu_pr_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("outputs active after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page not zero without eviction");

endmodule

bind lfu_page_replacement_core lfu_pr_checker u_lfu_pr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_hit           (rsp_chan.hit),
   .rsp_evicted_valid (rsp_chan.evicted_valid),
   .rsp_evicted_page  (rsp_chan.evicted_page)
);
